### sv/gbwns_pkg.sv
// ----------------------------------------------------------------------------
// gbwns_pkg
// Shared constants, register and command codes, and structs for the grid box
// window neighbour sum block.
// ----------------------------------------------------------------------------
package gbwns_pkg;

   localparam int MAX_DIMS       = 3;
   localparam int SIDE_MAX       = 16;
   localparam int WINDOW_MAX     = 7;
   localparam int COUNT_BITS_DEF = 16;

   localparam int DIM_N   = 3;
   localparam int CMD_W   = 2;
   localparam int BOX_W   = 12;
   localparam int COORD_W = 4;
   localparam int NB_W    = 9;
   localparam int SUM_W   = 32;
   localparam int DIMS_W  = 2;
   localparam int NP_W    = 5;
   localparam int WIN_W   = 3;

   localparam int STORE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int DIMS_EFF_MAX = (MAX_DIMS < DIM_N) ? MAX_DIMS : DIM_N;
   localparam int WIN_EFF_MAX  = (WINDOW_MAX < (2**WIN_W - 1)) ? WINDOW_MAX : (2**WIN_W - 1);
   localparam int HALF_MAX     = (WIN_EFF_MAX - 1) / 2;
   localparam int HALF_W       = (HALF_MAX < 2) ? 1 : $clog2(HALF_MAX + 1);
   localparam int OFS_W        = HALF_W + 1;
   localparam int POS_W        = $clog2(2**COORD_W + HALF_MAX) + 1;
   localparam int UPOS_W       = POS_W - 1;
   localparam int S2_W         = 2 * NP_W;
   localparam int IDX_W        = UPOS_W + S2_W + 1;

   localparam int REQ_DATA_W = ((BOX_W + DIM_N * COORD_W + 7) / 8) * 8;
   localparam int RSP_USED_W = NB_W + SUM_W + 1;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CMD_W-1:0] CMD_COUNT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_DIMS    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PARTS_0 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PARTS_1 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PARTS_2 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_MAX_SUM = 3'd5;

   localparam logic [DIMS_W-1:0] DIMS_RST    = 2'd2;
   localparam logic [NP_W-1:0]   PARTS_RST   = 5'd16;
   localparam logic [WIN_W-1:0]  WINDOW_RST  = 3'd3;
   localparam logic [SUM_W-1:0]  MAX_SUM_RST = '1;

   typedef struct packed {
      logic [DIMS_W-1:0]           nd;
      logic [HALF_W-1:0]           half;
      logic [DIM_N-1:0][NP_W-1:0]  np;
      logic [SUM_W-1:0]            max_sum;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic in_grid;
      logic hit;
      logic last;
   } tag_type;

   typedef struct packed {
      tag_type             tag;
      logic [ADDR_W-1:0]   addr;
   } pos_type;

endpackage

### sv/gbwns_csr.sv
// ----------------------------------------------------------------------------
// gbwns_csr
// Configuration registers behind the bus port, with the clamped working
// values handed to the datapath.
// ----------------------------------------------------------------------------
module gbwns_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gbwns_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [gbwns_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [gbwns_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready,
   output gbwns_pkg::cfg_type                  cfg
);

   logic [gbwns_pkg::DIMS_W-1:0]                        dims_ff, dims_in;
   logic [gbwns_pkg::DIM_N-1:0][gbwns_pkg::NP_W-1:0]    parts_ff, parts_in;
   logic [gbwns_pkg::WIN_W-1:0]                         window_ff, window_in;
   logic [gbwns_pkg::SUM_W-1:0]                         max_sum_ff, max_sum_in;
   logic [gbwns_pkg::REG_IDX_W-1:0]                     reg_idx;
   logic                                                wr;
   logic [gbwns_pkg::WIN_W-1:0]                         win_eff;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[gbwns_pkg::CSR_ADDR_W-1:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      dims_in    = dims_ff;
      parts_in   = parts_ff;
      window_in  = window_ff;
      max_sum_in = max_sum_ff;
      if (wr) begin
         case (reg_idx)
            gbwns_pkg::REG_DIMS:    dims_in     = csr_pwdata[gbwns_pkg::DIMS_W-1:0];
            gbwns_pkg::REG_PARTS_0: parts_in[0] = csr_pwdata[gbwns_pkg::NP_W-1:0];
            gbwns_pkg::REG_PARTS_1: parts_in[1] = csr_pwdata[gbwns_pkg::NP_W-1:0];
            gbwns_pkg::REG_PARTS_2: parts_in[2] = csr_pwdata[gbwns_pkg::NP_W-1:0];
            gbwns_pkg::REG_WINDOW:  window_in   = csr_pwdata[gbwns_pkg::WIN_W-1:0];
            gbwns_pkg::REG_MAX_SUM: max_sum_in  = csr_pwdata[gbwns_pkg::SUM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff    <= gbwns_pkg::DIMS_RST;
         parts_ff   <= {gbwns_pkg::DIM_N{gbwns_pkg::PARTS_RST}};
         window_ff  <= gbwns_pkg::WINDOW_RST;
         max_sum_ff <= gbwns_pkg::MAX_SUM_RST;
      end else begin
         dims_ff    <= dims_in;
         parts_ff   <= parts_in;
         window_ff  <= window_in;
         max_sum_ff <= max_sum_in;
      end
   end

   always_comb begin
      case (reg_idx)
         gbwns_pkg::REG_DIMS:
            csr_prdata = gbwns_pkg::CSR_DATA_W'(dims_ff);
         gbwns_pkg::REG_PARTS_0:
            csr_prdata = gbwns_pkg::CSR_DATA_W'(parts_ff[0]);
         gbwns_pkg::REG_PARTS_1:
            csr_prdata = gbwns_pkg::CSR_DATA_W'(parts_ff[1]);
         gbwns_pkg::REG_PARTS_2:
            csr_prdata = gbwns_pkg::CSR_DATA_W'(parts_ff[2]);
         gbwns_pkg::REG_WINDOW:
            csr_prdata = gbwns_pkg::CSR_DATA_W'(window_ff);
         gbwns_pkg::REG_MAX_SUM:
            csr_prdata = gbwns_pkg::CSR_DATA_W'(max_sum_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // clamped working values
   always_comb begin
      if (dims_ff == '0) begin
         cfg.nd = gbwns_pkg::DIMS_W'(1);
      end else if (32'(dims_ff) > gbwns_pkg::DIMS_EFF_MAX) begin
         cfg.nd = gbwns_pkg::DIMS_W'(gbwns_pkg::DIMS_EFF_MAX);
      end else begin
         cfg.nd = dims_ff;
      end

      for (int i = 0; i < gbwns_pkg::DIM_N; i++) begin
         if (32'(parts_ff[i]) > gbwns_pkg::SIDE_MAX) begin
            cfg.np[i] = gbwns_pkg::NP_W'(gbwns_pkg::SIDE_MAX);
         end else begin
            cfg.np[i] = parts_ff[i];
         end
      end

      if (window_ff == '0) begin
         win_eff = gbwns_pkg::WIN_W'(1);
      end else if (32'(window_ff) > gbwns_pkg::WIN_EFF_MAX) begin
         win_eff = gbwns_pkg::WIN_W'(gbwns_pkg::WIN_EFF_MAX);
      end else begin
         win_eff = window_ff;
      end
      cfg.half    = gbwns_pkg::HALF_W'((win_eff - gbwns_pkg::WIN_W'(1)) >> 1);
      cfg.max_sum = max_sum_ff;
   end

endmodule

### sv/gbwns_store.sv
// ----------------------------------------------------------------------------
// gbwns_store
// Box count memory, one read and one write port, with a zeroing sweep that
// runs after reset and on request.
// ----------------------------------------------------------------------------
module gbwns_store #(
   parameter int COUNT_BITS = gbwns_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             sweep_go,
   output logic                             sweep_busy,
   input  logic                             rd_en,
   input  logic [gbwns_pkg::ADDR_W-1:0]     rd_addr,
   output logic [COUNT_BITS-1:0]            rd_data,
   input  logic                             wr_en,
   input  logic [gbwns_pkg::ADDR_W-1:0]     wr_addr,
   input  logic [COUNT_BITS-1:0]            wr_data
);

   localparam logic [gbwns_pkg::ADDR_W-1:0] LAST_ADDR =
      gbwns_pkg::ADDR_W'(gbwns_pkg::STORE_DEPTH - 1);

   logic [COUNT_BITS-1:0]          mem [gbwns_pkg::STORE_DEPTH];
   logic [COUNT_BITS-1:0]          rd_data_ff;
   logic                           sweep_ff, sweep_in;
   logic [gbwns_pkg::ADDR_W-1:0]   sweep_addr_ff, sweep_addr_in;

   assign sweep_busy = sweep_ff;
   assign rd_data    = rd_data_ff;

   always_comb begin
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      if (sweep_go) begin
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
      end else if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + gbwns_pkg::ADDR_W'(1);
         if (sweep_addr_ff == LAST_ADDR) begin
            sweep_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
      end else begin
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sweep_ff) begin
         mem[sweep_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

### sv/gbwns_walk.sv
// ----------------------------------------------------------------------------
// gbwns_walk
// Window sequencer: steps the offset counters over the cube window, one
// position per cycle, and forms the in-grid test and the linear box address.
// ----------------------------------------------------------------------------
module gbwns_walk (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            start,
   input  gbwns_pkg::cfg_type                              cfg,
   input  logic [gbwns_pkg::DIM_N-1:0][gbwns_pkg::COORD_W-1:0] centre,
   output gbwns_pkg::pos_type                              pos
);

   localparam int N  = gbwns_pkg::DIM_N;
   localparam int PW = gbwns_pkg::POS_W;
   localparam int UW = gbwns_pkg::UPOS_W;
   localparam int OW = gbwns_pkg::OFS_W;
   localparam int XW = gbwns_pkg::IDX_W;

   logic                               active_ff, active_in;
   logic [N-1:0]                       use_ff, use_in;
   logic signed [OW-1:0]               hi_ff [N];
   logic signed [OW-1:0]               hi_in [N];
   logic signed [OW-1:0]               ofs_ff [N];
   logic signed [OW-1:0]               ofs_in [N];
   logic [gbwns_pkg::COORD_W-1:0]      c_ff [N];
   logic [gbwns_pkg::COORD_W-1:0]      c_in [N];
   logic [gbwns_pkg::NP_W-1:0]         np_ff [N];
   logic [gbwns_pkg::NP_W-1:0]         np_in [N];
   logic [gbwns_pkg::S2_W-1:0]         s2_ff, s2_in;
   gbwns_pkg::pos_type                 pos_ff, pos_in;

   logic [PW-1:0]                      p [N];
   logic                               in_grid;
   logic                               carry;
   logic [XW-1:0]                      idx;

   assign pos = pos_ff;

   // position, in-grid test and linear address
   always_comb begin
      in_grid = 1'b1;
      for (int i = 0; i < N; i++) begin
         p[i] = {{(PW - gbwns_pkg::COORD_W){1'b0}}, c_ff[i]}
              + {{(PW - OW){ofs_ff[i][OW-1]}}, ofs_ff[i]};
         if (use_ff[i] && (p[i][PW-1] || (32'(p[i][UW-1:0]) >= 32'(np_ff[i])))) begin
            in_grid = 1'b0;
         end
      end
      idx = XW'(p[0][UW-1:0])
          + XW'(p[1][UW-1:0]) * XW'(np_ff[0])
          + XW'(p[2][UW-1:0]) * XW'(s2_ff);
   end

   always_comb begin
      active_in = active_ff;
      use_in    = use_ff;
      s2_in     = s2_ff;
      carry     = 1'b1;
      for (int i = 0; i < N; i++) begin
         hi_in[i]  = hi_ff[i];
         c_in[i]   = c_ff[i];
         np_in[i]  = np_ff[i];
         ofs_in[i] = ofs_ff[i];
         if (carry) begin
            if (ofs_ff[i] == hi_ff[i]) begin
               ofs_in[i] = -hi_ff[i];
            end else begin
               ofs_in[i] = ofs_ff[i] + OW'(1);
               carry     = 1'b0;
            end
         end
      end
      if (active_ff && carry) begin
         active_in = 1'b0;
      end

      if (start) begin
         active_in = 1'b1;
         s2_in     = gbwns_pkg::S2_W'(cfg.np[0]) * gbwns_pkg::S2_W'(cfg.np[1]);
         for (int i = 0; i < N; i++) begin
            use_in[i] = (i < int'(cfg.nd));
            np_in[i]  = cfg.np[i];
            if (use_in[i]) begin
               hi_in[i] = {1'b0, cfg.half};
               c_in[i]  = centre[i];
            end else begin
               hi_in[i] = '0;
               c_in[i]  = '0;
            end
            ofs_in[i] = -hi_in[i];
         end
      end

      pos_in.tag.valid   = active_ff;
      pos_in.tag.in_grid = in_grid;
      pos_in.tag.hit     = in_grid && (32'(idx) < gbwns_pkg::STORE_DEPTH);
      pos_in.tag.last    = carry;
      pos_in.addr        = idx[gbwns_pkg::ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         pos_ff.tag    <= '0;
      end else begin
         active_ff     <= active_in;
         pos_ff.tag    <= pos_in.tag;
      end
      pos_ff.addr <= pos_in.addr;
   end

   always_ff @(posedge clock) begin
      use_ff      <= use_in;
      s2_ff       <= s2_in;
      for (int i = 0; i < N; i++) begin
         hi_ff[i]  <= hi_in[i];
         ofs_ff[i] <= ofs_in[i];
         c_ff[i]   <= c_in[i];
         np_ff[i]  <= np_in[i];
      end
   end

endmodule

### sv/gbwns_accum.sv
// ----------------------------------------------------------------------------
// gbwns_accum
// Shared accumulator: neighbour counter, saturating window sum and the limit
// compare.
// ----------------------------------------------------------------------------
module gbwns_accum #(
   parameter int COUNT_BITS = gbwns_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             start,
   input  gbwns_pkg::tag_type               tag,
   input  logic [COUNT_BITS-1:0]            value,
   input  logic [gbwns_pkg::SUM_W-1:0]      max_sum,
   output logic [gbwns_pkg::NB_W-1:0]       neighbours,
   output logic [gbwns_pkg::SUM_W-1:0]      window_sum,
   output logic                             too_many
);

   localparam int WIDE_W = gbwns_pkg::SUM_W + 1;

   logic [gbwns_pkg::NB_W-1:0]     count_ff, count_in;
   logic [gbwns_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [WIDE_W-1:0]              sum_wide;
   logic [COUNT_BITS-1:0]          addend;

   assign neighbours = count_ff;
   assign window_sum = sum_ff;
   assign too_many   = sum_ff > max_sum;

   always_comb begin
      addend   = tag.hit ? value : '0;
      sum_wide = {1'b0, sum_ff} + WIDE_W'(addend);
      count_in = count_ff;
      sum_in   = sum_ff;
      if (start) begin
         count_in = '0;
         sum_in   = '0;
      end else if (tag.valid) begin
         count_in = count_ff + gbwns_pkg::NB_W'(tag.in_grid);
         sum_in   = sum_wide[WIDE_W-1] ? '1 : sum_wide[gbwns_pkg::SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      sum_ff   <= sum_in;
   end

endmodule

### sv/grid_box_window_neighbour_sum.sv
// ----------------------------------------------------------------------------
// grid_box_window_neighbour_sum
// Count: each beat reads the box count and writes it back plus one, saturating. Query:
// one box read per cycle on the single read port of the count store.
// Clear: one store entry zeroed per cycle.
// Reset: a zeroing pass over all 4096 count store entries, req_tready low
// meanwhile; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module grid_box_window_neighbour_sum #(
   parameter int COUNT_BITS = gbwns_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // box, coord_0, coord_1, coord_2
   input  logic [gbwns_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd
   input  logic [gbwns_pkg::CMD_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // neighbours, window_sum, too_many, zero fill
   output logic [gbwns_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gbwns_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [gbwns_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [gbwns_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   typedef enum logic [7:0] {
      S_INIT     = 8'b0000_0001,
      S_IDLE     = 8'b0000_0010,
      S_COUNT_RD = 8'b0000_0100,
      S_COUNT_WR = 8'b0000_1000,
      S_CLEAR    = 8'b0001_0000,
      S_SETUP    = 8'b0010_0000,
      S_WALK     = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   localparam int CW = gbwns_pkg::DIM_N * gbwns_pkg::COORD_W;
   localparam int PAD_W = gbwns_pkg::RSP_DATA_W - gbwns_pkg::RSP_USED_W;

   state_type                                            state_ff, state_in;
   logic [gbwns_pkg::BOX_W-1:0]                          box_ff, box_in;
   logic [gbwns_pkg::DIM_N-1:0][gbwns_pkg::COORD_W-1:0]  centre_ff, centre_in;
   gbwns_pkg::tag_type                                   tag_ff;
   logic                                                 rsp_valid_ff, rsp_valid_in;
   logic [gbwns_pkg::RSP_DATA_W-1:0]                     rsp_data_ff, rsp_data_in;

   gbwns_pkg::cfg_type                 cfg;
   gbwns_pkg::pos_type                 pos;
   logic                               accept;
   logic                               load;
   logic                               sweep_go;
   logic                               sweep_busy;
   logic                               rd_en;
   logic [gbwns_pkg::ADDR_W-1:0]       rd_addr;
   logic [COUNT_BITS-1:0]              rd_data;
   logic                               wr_en;
   logic [COUNT_BITS-1:0]              wr_data;
   logic [gbwns_pkg::NB_W-1:0]         neighbours;
   logic [gbwns_pkg::SUM_W-1:0]        window_sum;
   logic                               too_many;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign sweep_go   = accept && (req_tuser == gbwns_pkg::CMD_CLEAR);
   assign load       = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign rd_en   = (state_ff == S_COUNT_RD) || (pos.tag.valid && pos.tag.hit);
   assign rd_addr = (state_ff == S_COUNT_RD) ? gbwns_pkg::ADDR_W'(box_ff) : pos.addr;
   assign wr_en   = (state_ff == S_COUNT_WR);
   assign wr_data = (rd_data == '1) ? rd_data : rd_data + COUNT_BITS'(1);

   gbwns_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gbwns_store #(.COUNT_BITS(COUNT_BITS)) u_store (
      .clock      (clock),
      .reset      (reset),
      .sweep_go   (sweep_go),
      .sweep_busy (sweep_busy),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (gbwns_pkg::ADDR_W'(box_ff)),
      .wr_data    (wr_data)
   );

   gbwns_walk u_walk (
      .clock  (clock),
      .reset  (reset),
      .start  (state_ff == S_SETUP),
      .cfg    (cfg),
      .centre (centre_ff),
      .pos    (pos)
   );

   gbwns_accum #(.COUNT_BITS(COUNT_BITS)) u_accum (
      .clock      (clock),
      .start      (accept),
      .tag        (tag_ff),
      .value      (rd_data),
      .max_sum    (cfg.max_sum),
      .neighbours (neighbours),
      .window_sum (window_sum),
      .too_many   (too_many)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            if (!sweep_busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  gbwns_pkg::CMD_COUNT: state_in = S_COUNT_RD;
                  gbwns_pkg::CMD_QUERY: state_in = S_SETUP;
                  gbwns_pkg::CMD_CLEAR: state_in = S_CLEAR;
                  default:              state_in = S_DONE;
               endcase
            end
         end
         S_COUNT_RD: state_in = S_COUNT_WR;
         S_COUNT_WR: state_in = S_DONE;
         S_CLEAR: begin
            if (!sweep_busy) begin
               state_in = S_DONE;
            end
         end
         S_SETUP: state_in = S_WALK;
         S_WALK: begin
            if (tag_ff.valid && tag_ff.last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_comb begin
      box_in    = box_ff;
      centre_in = centre_ff;
      if (accept) begin
         box_in    = req_tdata[gbwns_pkg::BOX_W-1:0];
         centre_in = req_tdata[gbwns_pkg::BOX_W +: CW];
      end

      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_data_in  = {{PAD_W{1'b0}}, too_many, window_sum, neighbours};
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         tag_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tag_ff       <= pos.tag;
      end
   end

   always_ff @(posedge clock) begin
      box_ff      <= box_in;
      centre_ff   <= centre_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### sv/gbwns_checker.sv
// ----------------------------------------------------------------------------
// gbwns_checker
// Port-level checks for the grid box window neighbour sum block, bound to
// the top level.
// ----------------------------------------------------------------------------
module gbwns_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [gbwns_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int NB_W = gbwns_pkg::NB_W;
   localparam int SUM_W = gbwns_pkg::SUM_W;
   localparam int USED_W = gbwns_pkg::RSP_USED_W;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // one item at a time
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in work");

   // empty window sums to zero
   a_empty_window: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[NB_W-1:0] == '0) |-> (rsp_tdata[NB_W +: SUM_W] == '0))
      else $error("nonzero sum with no neighbours");

   // fill bits of the result are zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[gbwns_pkg::RSP_DATA_W-1:USED_W] == '0))
      else $error("result fill bits not zero");

endmodule

bind grid_box_window_neighbour_sum gbwns_checker u_gbwns_checker (.*);

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid box window neighbour sum block. A queue of
// count, query, clear and unused-code beats is streamed in with random gaps on
// both sides, and every result beat is checked against an in-bench predictor
// that keeps its own copy of the box counts and of the grid registers. The
// bench runs through several grid settings, including the register extremes,
// and ends with a run that pushes one window sum across the limit.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CMD_W          = gbwns_pkg::CMD_W;
   localparam int DIM_N          = gbwns_pkg::DIM_N;
   localparam int COORD_W        = gbwns_pkg::COORD_W;
   localparam int BOX_W          = gbwns_pkg::BOX_W;
   localparam int NB_W           = gbwns_pkg::NB_W;
   localparam int SUM_W          = gbwns_pkg::SUM_W;
   localparam int REQ_DATA_W     = gbwns_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W     = gbwns_pkg::RSP_DATA_W;
   localparam int CSR_ADDR_W     = gbwns_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W     = gbwns_pkg::CSR_DATA_W;
   localparam int REG_IDX_W      = gbwns_pkg::REG_IDX_W;
   localparam int DIMS_W         = gbwns_pkg::DIMS_W;
   localparam int NP_W           = gbwns_pkg::NP_W;
   localparam int WIN_W          = gbwns_pkg::WIN_W;
   localparam int COUNT_BITS_DEF = gbwns_pkg::COUNT_BITS_DEF;
   localparam int STORE_DEPTH    = gbwns_pkg::STORE_DEPTH;
   localparam int MAX_DIMS       = gbwns_pkg::MAX_DIMS;
   localparam int SIDE_MAX       = gbwns_pkg::SIDE_MAX;
   localparam int WINDOW_MAX     = gbwns_pkg::WINDOW_MAX;

   localparam logic [CMD_W-1:0] CMD_COUNT = gbwns_pkg::CMD_COUNT;
   localparam logic [CMD_W-1:0] CMD_QUERY = gbwns_pkg::CMD_QUERY;
   localparam logic [CMD_W-1:0] CMD_CLEAR = gbwns_pkg::CMD_CLEAR;

   localparam logic [REG_IDX_W-1:0] REG_DIMS    = gbwns_pkg::REG_DIMS;
   localparam logic [REG_IDX_W-1:0] REG_PARTS_0 = gbwns_pkg::REG_PARTS_0;
   localparam logic [REG_IDX_W-1:0] REG_PARTS_1 = gbwns_pkg::REG_PARTS_1;
   localparam logic [REG_IDX_W-1:0] REG_PARTS_2 = gbwns_pkg::REG_PARTS_2;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW  = gbwns_pkg::REG_WINDOW;
   localparam logic [REG_IDX_W-1:0] REG_MAX_SUM = gbwns_pkg::REG_MAX_SUM;

   localparam logic [DIMS_W-1:0] DIMS_RST    = gbwns_pkg::DIMS_RST;
   localparam logic [NP_W-1:0]   PARTS_RST   = gbwns_pkg::PARTS_RST;
   localparam logic [WIN_W-1:0]  WINDOW_RST  = gbwns_pkg::WINDOW_RST;
   localparam logic [SUM_W-1:0]  MAX_SUM_RST = gbwns_pkg::MAX_SUM_RST;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 20000;
   localparam int RANDOM_PHASES = 9;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int LIMIT_COUNTS = 20;

   typedef struct packed {
      logic [CMD_W-1:0]                cmd;
      logic [DIM_N-1:0][COORD_W-1:0]   coord;
      logic [BOX_W-1:0]                box;
   } grid_req_type;

   typedef struct packed {
      logic [NB_W-1:0]   neighbours;
      logic [SUM_W-1:0]  window_sum;
      logic              too_many;
   } window_ans_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [CMD_W-1:0]       req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   grid_box_window_neighbour_sum i_dut (.*);

   // grid registers and box counts as the block should hold them
   logic [DIMS_W-1:0]          dims_reg = DIMS_RST;
   logic [NP_W-1:0]            parts_reg [DIM_N] = '{PARTS_RST, PARTS_RST, PARTS_RST};
   logic [WIN_W-1:0]           window_reg = WINDOW_RST;
   logic [SUM_W-1:0]           max_sum_reg = MAX_SUM_RST;
   logic [COUNT_BITS_DEF-1:0]  point_counts [STORE_DEPTH];

   grid_req_type     queued_requests [$];
   window_ans_type   owed_answers [$];
   grid_req_type     cur_req;
   bit               no_gaps = 1'b0;
   int               mismatch_count = 0;
   int               quiet_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int grid_dims();
      int d;
      d = dims_reg;
      if (d < 1) d = 1;
      if (d > MAX_DIMS) d = MAX_DIMS;
      if (d > 3) d = 3;
      return d;
   endfunction

   function automatic int grid_parts(int i);
      return (parts_reg[i] > SIDE_MAX) ? SIDE_MAX : int'(parts_reg[i]);
   endfunction

   function automatic void zero_counts();
      foreach (point_counts[j]) point_counts[j] = '0;
   endfunction

   function automatic window_ans_type window_census(grid_req_type r);
      window_ans_type ans;
      int nd, w, half, a, b, k, i, idx, hits;
      int np [3];
      int c [3];
      int lo [3];
      int hi [3];
      int p [3];
      longint total;
      bit in_grid;
      nd = grid_dims();
      w = window_reg;
      if (w < 1) w = 1;
      if (w > WINDOW_MAX) w = WINDOW_MAX;
      half = (w - 1) / 2;
      hits = 0;
      total = 0;
      for (i = 0; i < 3; i++) begin
         np[i] = grid_parts(i);
         c[i] = (i < nd) ? int'(r.coord[i]) : 0;
         lo[i] = (i < nd) ? -half : 0;
         hi[i] = (i < nd) ? half : 0;
      end
      for (k = lo[2]; k <= hi[2]; k++) begin
         for (b = lo[1]; b <= hi[1]; b++) begin
            for (a = lo[0]; a <= hi[0]; a++) begin
               p[0] = c[0] + a;
               p[1] = c[1] + b;
               p[2] = c[2] + k;
               in_grid = 1'b1;
               for (i = 0; i < nd; i++) begin
                  if (p[i] < 0 || p[i] >= np[i]) in_grid = 1'b0;
               end
               if (in_grid) begin
                  hits++;
                  idx = p[0];
                  if (nd > 1) idx += p[1] * np[0];
                  if (nd > 2) idx += p[2] * np[0] * np[1];
                  if (idx < STORE_DEPTH) begin
                     total += point_counts[idx];
                     if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
                  end
               end
            end
         end
      end
      ans.neighbours = NB_W'(hits);
      ans.window_sum = SUM_W'(total);
      ans.too_many = (total > longint'(max_sum_reg));
      return ans;
   endfunction

   function automatic window_ans_type serve_request(grid_req_type r);
      window_ans_type ans;
      ans = '0;
      case (r.cmd)
         CMD_COUNT: begin
            if (point_counts[r.box] != '1) point_counts[r.box] = point_counts[r.box] + 1'b1;
         end
         CMD_QUERY: begin
            ans = window_census(r);
         end
         CMD_CLEAR: begin
            zero_counts();
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   function automatic grid_req_type req_item(logic [CMD_W-1:0] cmd, int box, int c0, int c1,
                                             int c2);
      grid_req_type r;
      r.cmd = cmd;
      r.box = BOX_W'(box);
      r.coord[0] = COORD_W'(c0);
      r.coord[1] = COORD_W'(c1);
      r.coord[2] = COORD_W'(c2);
      return r;
   endfunction

   function automatic grid_req_type random_req();
      grid_req_type r;
      int nd, cells, i, pick, np;
      nd = grid_dims();
      cells = 1;
      for (i = 0; i < nd; i++) cells *= grid_parts(i);
      r.box = BOX_W'($urandom);
      r.coord = (DIM_N * COORD_W)'($urandom);
      pick = $urandom_range(99);
      if (pick < 52) begin
         r.cmd = CMD_COUNT;
         if (cells > 0 && $urandom_range(9) < 8) r.box = BOX_W'($urandom_range(cells - 1));
      end else if (pick < 93) begin
         r.cmd = CMD_QUERY;
         for (i = 0; i < nd; i++) begin
            np = grid_parts(i);
            if (np > 0 && $urandom_range(9) < 8)
               r.coord[i] = COORD_W'($urandom_range((np > 15) ? 15 : np));
         end
      end else if (pick < 98) begin
         r.cmd = CMD_UNUSED;
      end else begin
         r.cmd = CMD_CLEAR;
      end
      return r;
   endfunction

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_DIMS:    dims_reg = value[DIMS_W-1:0];
         REG_PARTS_0: parts_reg[0] = value[NP_W-1:0];
         REG_PARTS_1: parts_reg[1] = value[NP_W-1:0];
         REG_PARTS_2: parts_reg[2] = value[NP_W-1:0];
         REG_WINDOW:  window_reg = value[WIN_W-1:0];
         REG_MAX_SUM: max_sum_reg = value;
         default: ;
      endcase
   endtask

   task automatic set_grid(input int d, input int p0, input int p1, input int p2, input int w,
                           input logic [SUM_W-1:0] limit);
      csr_write(REG_DIMS, d);
      csr_write(REG_PARTS_0, p0);
      csr_write(REG_PARTS_1, p1);
      csr_write(REG_PARTS_2, p2);
      csr_write(REG_WINDOW, w);
      csr_write(REG_MAX_SUM, limit);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_tvalid || owed_answers.size() != 0);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) owed_answers.push_back(serve_request(cur_req));
         if (!req_tvalid || req_tready) begin
            if (queued_requests.size() != 0 && (no_gaps || $urandom_range(99) >= 34)) begin
               cur_req = queued_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= REQ_DATA_W'({cur_req.coord, cur_req.box});
               req_tuser <= cur_req.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : result_check
      window_ans_type want;
      logic [NB_W-1:0]  got_nb;
      logic [SUM_W-1:0] got_sum;
      logic             got_flag;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_nb = rsp_tdata[NB_W-1:0];
            got_sum = rsp_tdata[NB_W +: SUM_W];
            got_flag = rsp_tdata[NB_W + SUM_W];
            if (owed_answers.size() == 0) begin
               $error("result beat with no request outstanding");
               mismatch_count++;
            end else begin
               want = owed_answers.pop_front();
               if (got_nb !== want.neighbours) begin
                  $error("neighbours: expected %0d, got %0d", want.neighbours, got_nb);
                  mismatch_count++;
               end
               if (got_sum !== want.window_sum) begin
                  $error("window_sum: expected %0d, got %0d", want.window_sum, got_sum);
                  mismatch_count++;
               end
               if (got_flag !== want.too_many) begin
                  $error("too_many: expected %0d, got %0d", want.too_many, got_flag);
                  mismatch_count++;
               end
            end
         end
         rsp_tready <= no_gaps || ($urandom_range(99) >= 34);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int ph, n;
      zero_counts();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset register values: 2-d, 16 x 16, window 3
      queued_requests.push_back(req_item(CMD_QUERY, 0, 0, 0, 0));
      queued_requests.push_back(req_item(CMD_COUNT, 0, 0, 0, 0));
      queued_requests.push_back(req_item(CMD_COUNT, 4095, 15, 15, 15));
      queued_requests.push_back(req_item(CMD_COUNT, 17, 0, 0, 0));
      queued_requests.push_back(req_item(CMD_COUNT, 17, 0, 0, 0));
      queued_requests.push_back(req_item(CMD_COUNT, 16, 0, 0, 0));
      queued_requests.push_back(req_item(CMD_QUERY, 4095, 1, 1, 0));
      queued_requests.push_back(req_item(CMD_UNUSED, 17, 1, 1, 0));
      queued_requests.push_back(req_item(CMD_QUERY, 0, 1, 1, 15));
      queued_requests.push_back(req_item(CMD_QUERY, 0, 8, 8, 0));
      queued_requests.push_back(req_item(CMD_COUNT, 255, 0, 0, 0));
      queued_requests.push_back(req_item(CMD_QUERY, 0, 15, 15, 0));
      queued_requests.push_back(req_item(CMD_QUERY, 0, 0, 15, 0));
      queued_requests.push_back(req_item(CMD_COUNT, 'hAAA, 5, 10, 5));
      queued_requests.push_back(req_item(CMD_COUNT, 'h555, 10, 5, 10));
      queued_requests.push_back(req_item(CMD_QUERY, 'h555, 10, 10, 10));
      queued_requests.push_back(req_item(CMD_QUERY, 'hAAA, 5, 5, 5));
      queued_requests.push_back(req_item(CMD_CLEAR, 'hFFF, 15, 15, 15));
      queued_requests.push_back(req_item(CMD_QUERY, 0, 1, 1, 0));
      queued_requests.push_back(req_item(CMD_QUERY, 0, 15, 0, 0));
      drain();

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: set_grid(3, 16, 16, 16, 7, 0);
            1: set_grid(1, 31, 0, 17, 0, 3);
            2: set_grid(0, 1, 16, 16, 6, 2);
            3: set_grid(3, 3, 5, 2, 4, 10);
            4: set_grid(2, 0, 7, 3, 5, 1);
            5: set_grid(3, 16, 1, 4, 2, 20);
            default: set_grid($urandom_range(3), $urandom_range(31), $urandom_range(31),
                              $urandom_range(31), $urandom_range(7),
                              $urandom_range(1) ? $urandom_range(40) : $urandom);
         endcase
         no_gaps = (ph == 2);
         for (n = 0; n < ITEMS_PER_PHASE; n++) queued_requests.push_back(random_req());
         drain();
      end

      // build one window sum around the limit, then check the flag on both sides
      no_gaps = 1'b1;
      set_grid(1, 16, 16, 16, 3, LIMIT_COUNTS - 1);
      queued_requests.push_back(req_item(CMD_COUNT, 4, 0, 0, 0));
      for (n = 0; n < LIMIT_COUNTS; n++) queued_requests.push_back(req_item(CMD_COUNT, 5, 0, 0, 0));
      queued_requests.push_back(req_item(CMD_QUERY, 0, 5, 0, 0));
      queued_requests.push_back(req_item(CMD_QUERY, 0, 6, 0, 0));
      queued_requests.push_back(req_item(CMD_QUERY, 0, 4, 0, 0));
      queued_requests.push_back(req_item(CMD_QUERY, 0, 3, 0, 0));
      queued_requests.push_back(req_item(CMD_QUERY, 0, 7, 0, 0));
      queued_requests.push_back(req_item(CMD_CLEAR, 0, 0, 0, 0));
      queued_requests.push_back(req_item(CMD_QUERY, 0, 5, 0, 0));
      drain();

      repeat (400) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
sv/gbwns_pkg.sv
sv/gbwns_csr.sv
sv/gbwns_store.sv
sv/gbwns_walk.sv
sv/gbwns_accum.sv
sv/grid_box_window_neighbour_sum.sv
sv/gbwns_checker.sv
test/tb.sv
